### src/prt_pkg.sv
// Shared types and constants for the proportional text renderer.
// Holds the item modes, the command passed from front to back and the FSM encodings.
// Depends on nothing; the front end, queue, back end and top level use it.
package prt_pkg;

    localparam int SCREEN_COLS_DEF = 240;
    localparam int SCREEN_ROWS_DEF = 160;
    localparam int GLYPH_ROWS_DEF  = 8;
    localparam int GLYPH_COUNT_DEF = 96;

    localparam int MAX_GLYPH_ROWS = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0]  CHAR_ESC     = 8'h1B;
    localparam logic [7:0]  CHAR_NL      = 8'h0A;
    localparam logic [7:0]  CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0]  CHAR_RBRACK  = 8'h5D;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_X       = 8'h78;
    localparam logic [7:0]  CHAR_FIRST   = 8'h20;
    localparam logic [7:0]  CHAR_LAST    = 8'h7F;
    localparam logic [14:0] COLOR_MASK   = 15'h7FFF;

    typedef enum logic [1:0] {
        MODE_LOAD_ROW   = 2'd0,
        MODE_LOAD_WIDTH = 2'd1,
        MODE_START      = 2'd2,
        MODE_CHAR       = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_DRAW  = 2'd1,
        OP_ABORT = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [6:0]  glyph;
        logic [2:0]  row;
        logic [7:0]  bits;
        logic [3:0]  width;
        logic [15:0] base;
        logic [14:0] color;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_DRAW = 2'b10
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_FETCH = 4'b0010,
        B_EMIT  = 4'b0100,
        B_ABORT = 4'b1000
    } t_bstate;

    typedef enum logic [4:0] {
        ESC_NONE    = 5'b00001,
        ESC_BRACKET = 5'b00010,
        ESC_ZERO    = 5'b00100,
        ESC_X       = 5'b01000,
        ESC_HEX     = 5'b10000
    } t_esc;

endpackage

### src/prt_front.sv
// Front end of the text renderer: takes input items, keeps cursor, colour and escape state.
// Owns the glyph width store and issues load, draw and abort commands to the queue.
// Depends on prt_pkg.
module prt_front #(
    parameter int SCREEN_COLS = prt_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = prt_pkg::SCREEN_ROWS_DEF,
    parameter int GLYPH_ROWS  = prt_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = prt_pkg::GLYPH_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [6:0]        i_glyph_index,
    input  logic [2:0]        i_row_index,
    input  logic [7:0]        i_row_bits,
    input  logic [3:0]        i_glyph_width,
    input  logic [7:0]        i_start_x,
    input  logic [7:0]        i_start_y,
    input  logic [14:0]       i_start_color,
    input  logic [7:0]        i_char_code,
    input  logic              i_q_full,
    output logic              o_push,
    output prt_pkg::t_cmd     o_cmd
);

    localparam int COL_W = $clog2(SCREEN_COLS + 272);
    localparam int ROW_W = $clog2(SCREEN_ROWS + 264);
    localparam int GI_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam logic [15:0]    COLS16 = 16'(SCREEN_COLS);
    localparam logic [15:0]    LINE16 = 16'(GLYPH_ROWS * SCREEN_COLS);
    localparam logic [COL_W:0] COLS_X = (COL_W + 1)'(SCREEN_COLS);
    localparam logic [ROW_W:0] ROWS_X = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [ROW_W:0] GR_X   = (ROW_W + 1)'(GLYPH_ROWS);

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    prt_pkg::t_fstate r_state, n_state;
    prt_pkg::t_esc    r_esc, n_esc;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [7:0]       r_line_col, n_line_col;
    logic [15:0]      r_row_addr, n_row_addr;
    logic [14:0]      r_color, n_color;
    logic [15:0]      r_hex, n_hex;
    logic [2:0]       r_hex_cnt, n_hex_cnt;
    logic             r_halted, n_halted;
    logic [6:0]       r_glyph, n_glyph;
    logic [3:0]       r_wmem [GLYPH_COUNT];
    logic [3:0]       r_wdata;

    logic             accept;
    logic [7:0]       glyph_code;
    logic             printable;
    logic [4:0]       hv;
    logic [ROW_W:0]   row_next;
    logic             nl_off;
    logic             start_off;
    logic             wrap;

    assign o_in_ready = (r_state == prt_pkg::F_IDLE) && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign glyph_code = i_char_code - prt_pkg::CHAR_FIRST;
    assign printable  = (i_char_code >= prt_pkg::CHAR_FIRST) && (i_char_code <= prt_pkg::CHAR_LAST)
                        && (32'(glyph_code) < GLYPH_COUNT);
    assign hv         = hex_val(i_char_code);
    assign row_next   = {1'b0, r_row} + GR_X;
    assign nl_off     = (row_next + GR_X) > ROWS_X;
    assign start_off  = ((ROW_W + 1)'(i_start_y) + GR_X) > ROWS_X;
    assign wrap       = ({1'b0, r_col} + (COL_W + 1)'(r_wdata)) > COLS_X;

    always_ff @(posedge i_clk) begin
        if (accept && i_mode == prt_pkg::MODE_LOAD_WIDTH && 32'(i_glyph_index) < GLYPH_COUNT) begin
            r_wmem[GI_W'(i_glyph_index)] <= i_glyph_width;
        end
        if (accept && i_mode == prt_pkg::MODE_CHAR && printable) begin
            r_wdata <= r_wmem[GI_W'(glyph_code)];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_esc      = r_esc;
        n_col      = r_col;
        n_row      = r_row;
        n_line_col = r_line_col;
        n_row_addr = r_row_addr;
        n_color    = r_color;
        n_hex      = r_hex;
        n_hex_cnt  = r_hex_cnt;
        n_halted   = r_halted;
        n_glyph    = r_glyph;
        o_push     = 1'b0;
        o_cmd.op    = prt_pkg::OP_ABORT;
        o_cmd.glyph = i_glyph_index;
        o_cmd.row   = i_row_index;
        o_cmd.bits  = i_row_bits;
        o_cmd.width = r_wdata;
        o_cmd.base  = r_row_addr + 16'(r_col);
        o_cmd.color = r_color;

        unique case (r_state)
            prt_pkg::F_IDLE: begin
                if (accept) begin
                    unique case (prt_pkg::t_mode'(i_mode))
                        prt_pkg::MODE_LOAD_ROW: begin
                            if (32'(i_glyph_index) < GLYPH_COUNT
                                    && 32'(i_row_index) < GLYPH_ROWS) begin
                                o_push   = 1'b1;
                                o_cmd.op = prt_pkg::OP_LOAD;
                            end
                        end
                        prt_pkg::MODE_LOAD_WIDTH: begin
                        end
                        prt_pkg::MODE_START: begin
                            n_line_col = i_start_x;
                            n_col      = COL_W'(i_start_x);
                            n_row      = ROW_W'(i_start_y);
                            n_row_addr = 16'(i_start_y * COLS16);
                            n_color    = i_start_color & prt_pkg::COLOR_MASK;
                            n_esc      = prt_pkg::ESC_NONE;
                            n_hex      = '0;
                            n_hex_cnt  = '0;
                            n_halted   = start_off;
                            o_push     = start_off;
                        end
                        prt_pkg::MODE_CHAR: begin
                            if (!r_halted) begin
                                if (r_esc != prt_pkg::ESC_NONE) begin
                                    unique case (r_esc)
                                        prt_pkg::ESC_BRACKET: begin
                                            o_push = (i_char_code != prt_pkg::CHAR_LBRACK);
                                            n_esc  = prt_pkg::ESC_ZERO;
                                        end
                                        prt_pkg::ESC_ZERO: begin
                                            o_push = (i_char_code != prt_pkg::CHAR_ZERO);
                                            n_esc  = prt_pkg::ESC_X;
                                        end
                                        prt_pkg::ESC_X: begin
                                            o_push = (i_char_code != prt_pkg::CHAR_X);
                                            n_esc  = prt_pkg::ESC_HEX;
                                        end
                                        default: begin
                                            if (i_char_code == prt_pkg::CHAR_RBRACK) begin
                                                if (r_hex_cnt == 3'd0) begin
                                                    o_push = 1'b1;
                                                end else begin
                                                    n_color = r_hex[14:0];
                                                    n_esc   = prt_pkg::ESC_NONE;
                                                end
                                            end else if (!hv[4] || r_hex_cnt >= 3'd4) begin
                                                o_push = 1'b1;
                                            end else begin
                                                n_hex     = {r_hex[11:0], hv[3:0]};
                                                n_hex_cnt = r_hex_cnt + 3'd1;
                                            end
                                        end
                                    endcase
                                    if (o_push) begin
                                        n_halted = 1'b1;
                                        n_esc    = prt_pkg::ESC_NONE;
                                    end
                                end else if (i_char_code == prt_pkg::CHAR_NL) begin
                                    n_row      = ROW_W'(row_next);
                                    n_col      = COL_W'(r_line_col);
                                    n_row_addr = r_row_addr + LINE16;
                                    o_push     = nl_off;
                                    n_halted   = nl_off;
                                end else if (i_char_code == prt_pkg::CHAR_ESC) begin
                                    n_esc     = prt_pkg::ESC_BRACKET;
                                    n_hex     = '0;
                                    n_hex_cnt = '0;
                                end else if (printable) begin
                                    n_glyph = 7'(glyph_code);
                                    n_state = prt_pkg::F_DRAW;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            prt_pkg::F_DRAW: begin
                n_state = prt_pkg::F_IDLE;
                o_push  = 1'b1;
                if (wrap) begin
                    n_row      = ROW_W'(row_next);
                    n_row_addr = r_row_addr + LINE16;
                    if (nl_off) begin
                        n_halted = 1'b1;
                        n_col    = COL_W'(r_line_col);
                    end else begin
                        o_cmd.op    = prt_pkg::OP_DRAW;
                        o_cmd.base  = r_row_addr + LINE16 + 16'(r_line_col);
                        n_col       = COL_W'(r_line_col) + COL_W'(r_wdata);
                    end
                end else begin
                    o_cmd.op = prt_pkg::OP_DRAW;
                    n_col    = r_col + COL_W'(r_wdata);
                end
                o_cmd.glyph = r_glyph;
            end
            default: begin
                n_state = prt_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prt_pkg::F_IDLE;
            r_esc      <= prt_pkg::ESC_NONE;
            r_col      <= '0;
            r_row      <= '0;
            r_line_col <= '0;
            r_row_addr <= '0;
            r_color    <= '0;
            r_hex      <= '0;
            r_hex_cnt  <= '0;
            r_halted   <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_esc      <= n_esc;
            r_col      <= n_col;
            r_row      <= n_row;
            r_line_col <= n_line_col;
            r_row_addr <= n_row_addr;
            r_color    <= n_color;
            r_hex      <= n_hex;
            r_hex_cnt  <= n_hex_cnt;
            r_halted   <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
    end

endmodule

### src/prt_queue.sv
// Short command queue between the front and back ends of the text renderer.
// Holds prt_pkg::t_cmd entries in arrival order; depends on prt_pkg.
module prt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output prt_pkg::t_cmd o_head
);

    localparam int PTR_W = $clog2(prt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(prt_pkg::QUEUE_DEPTH + 1);

    prt_pkg::t_cmd    r_mem [prt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(prt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### src/prt_back.sv
// Back end of the text renderer: owns the glyph row store and turns commands into results.
// Fetches a glyph's rows, then emits one pixel write per cycle while the output is not stalled and
// the current row is not blank, through an output register. Depends on prt_pkg.
module prt_back #(
    parameter int SCREEN_COLS = prt_pkg::SCREEN_COLS_DEF,
    parameter int GLYPH_ROWS  = prt_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = prt_pkg::GLYPH_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  prt_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_kind,
    output logic [15:0]   o_pixel_address,
    output logic [14:0]   o_pixel_color,
    output logic          o_last
);

    localparam int FA_W = $clog2(GLYPH_COUNT * 8);
    localparam logic [15:0] COLS16 = 16'(SCREEN_COLS);

    prt_pkg::t_bstate r_state, n_state;
    logic [7:0]   r_font [GLYPH_COUNT * 8];
    logic [7:0]   r_rdata;
    logic [7:0]   r_rows [prt_pkg::MAX_GLYPH_ROWS];
    logic [6:0]   r_glyph;
    logic [7:0]   r_mask;
    logic [15:0]  r_base;
    logic [14:0]  r_color;
    logic [3:0]   r_fcnt;
    logic [2:0]   r_cur;

    logic         r_o_valid;
    logic         r_o_kind;
    logic [15:0]  r_o_addr;
    logic [14:0]  r_o_color;
    logic         r_o_last;

    logic         out_free;
    logic         font_we;
    logic [FA_W-1:0] font_waddr, font_raddr;
    logic [7:0]   rb;
    logic [2:0]   pos;
    logic         rest;
    logic         last_px;
    logic         emit_px;
    logic         emit_abort;
    logic [7:0]   head_mask;

    assign out_free   = !r_o_valid || i_out_ready;
    assign font_waddr = FA_W'({i_head.glyph, i_head.row});
    assign font_raddr = FA_W'({r_glyph, r_fcnt[2:0]});
    assign head_mask  = (i_head.width >= 4'd8) ? 8'hFF : 8'((9'd1 << i_head.width) - 9'd1);
    assign rb         = r_rows[r_cur];

    always_comb begin
        pos  = 3'd0;
        rest = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (rb[k]) begin
                pos = 3'(k);
            end
        end
        for (int k = 0; k < prt_pkg::MAX_GLYPH_ROWS; k++) begin
            if (k > int'(r_cur) && k < GLYPH_ROWS && r_rows[k] != 8'd0) begin
                rest = 1'b1;
            end
        end
    end

    assign last_px    = ((rb & (rb - 8'd1)) == 8'd0) && !rest;
    assign emit_px    = (r_state == prt_pkg::B_EMIT) && (rb != 8'd0) && out_free;
    assign emit_abort = (r_state == prt_pkg::B_ABORT) && out_free;
    assign o_pop      = (r_state == prt_pkg::B_IDLE) && !i_empty;
    assign font_we    = o_pop && (i_head.op == prt_pkg::OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (font_we) begin
            r_font[font_waddr] <= i_head.bits;
        end
        r_rdata <= r_font[font_raddr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prt_pkg::B_IDLE: begin
                if (o_pop) begin
                    unique case (i_head.op)
                        prt_pkg::OP_DRAW:  n_state = prt_pkg::B_FETCH;
                        prt_pkg::OP_ABORT: n_state = prt_pkg::B_ABORT;
                        default:           n_state = prt_pkg::B_IDLE;
                    endcase
                end
            end
            prt_pkg::B_FETCH: begin
                if (r_fcnt == 4'(GLYPH_ROWS)) begin
                    n_state = prt_pkg::B_EMIT;
                end
            end
            prt_pkg::B_EMIT: begin
                if (rb == 8'd0) begin
                    if (!rest || r_cur == 3'(GLYPH_ROWS - 1)) begin
                        n_state = prt_pkg::B_IDLE;
                    end
                end else if (emit_px && last_px) begin
                    n_state = prt_pkg::B_IDLE;
                end
            end
            prt_pkg::B_ABORT: begin
                if (emit_abort) begin
                    n_state = prt_pkg::B_IDLE;
                end
            end
            default: n_state = prt_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prt_pkg::B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_px || emit_abort) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_glyph <= i_head.glyph;
            r_mask  <= head_mask;
            r_base  <= i_head.base;
            r_color <= i_head.color;
            r_fcnt  <= 4'd0;
            r_cur   <= 3'd0;
        end
        if (r_state == prt_pkg::B_FETCH) begin
            if (r_fcnt != 4'd0) begin
                r_rows[3'(r_fcnt - 4'd1)] <= r_rdata & r_mask;
            end
            r_fcnt <= r_fcnt + 4'd1;
        end
        if (r_state == prt_pkg::B_EMIT) begin
            if (rb == 8'd0) begin
                r_cur  <= r_cur + 3'd1;
                r_base <= r_base + COLS16;
            end else if (emit_px) begin
                r_rows[r_cur] <= rb & ~(8'd1 << pos);
            end
        end
        if (emit_px) begin
            r_o_kind  <= 1'b0;
            r_o_addr  <= r_base + 16'(pos);
            r_o_color <= r_color;
            r_o_last  <= last_px;
        end else if (emit_abort) begin
            r_o_kind  <= 1'b1;
            r_o_addr  <= 16'd0;
            r_o_color <= 15'd0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = r_o_color;
    assign o_last          = r_o_last;

endmodule

### src/proportional_text_renderer_top.sv
// Top level of the proportional text renderer: front end, command queue and back end.
// Depends on prt_pkg, prt_front, prt_queue and prt_back.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_mode .. i_char_code
//   output    o_out_valid / i_out_ready  o_kind, o_pixel_address, o_pixel_color, o_last
//
// Load, start, newline and escape items are handled in the front end's idle state; a character
// also passes through its draw state after the glyph width store read, and input is not ready there.
// The back end pops a command in its idle state, reads the glyph row store in its fetch state,
// then emits the pixel writes in its emit state, stepping over blank rows before the last pixel.
// Reset is synchronous and active low; the font stores are not cleared and hold nothing useful
// until loaded. A stalled output holds the back end, and the four-entry queue then fills.
module proportional_text_renderer_top #(
    parameter int SCREEN_COLS = prt_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = prt_pkg::SCREEN_ROWS_DEF,
    parameter int GLYPH_ROWS  = prt_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = prt_pkg::GLYPH_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_glyph_index,
    input  logic [2:0]  i_row_index,
    input  logic [7:0]  i_row_bits,
    input  logic [3:0]  i_glyph_width,
    input  logic [7:0]  i_start_x,
    input  logic [7:0]  i_start_y,
    input  logic [14:0] i_start_color,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [15:0] o_pixel_address,
    output logic [14:0] o_pixel_color,
    output logic        o_last
);

    logic          push, full, pop, empty;
    prt_pkg::t_cmd push_cmd, head_cmd;

    prt_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_glyph_index (i_glyph_index),
        .i_row_index   (i_row_index),
        .i_row_bits    (i_row_bits),
        .i_glyph_width (i_glyph_width),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_start_color (i_start_color),
        .i_char_code   (i_char_code),
        .i_q_full      (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    prt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    prt_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last          (o_last)
    );

endmodule

### src/prt_checker.sv
// Port-level checks on the result channel of the proportional text renderer.
// Attached to proportional_text_renderer_top by the bind at the end; depends on nothing else.
module prt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [15:0] i_pixel_address,
    input logic [14:0] i_pixel_color,
    input logic        i_last
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid in the cycle after reset.");

    a_abort_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind |-> i_last)
        else $error("Abort result not marked as last.");

    a_abort_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind |-> i_pixel_address == 16'd0 && i_pixel_color == 15'd0)
        else $error("Abort result carries a non-zero address or colour.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_address)
            && $stable(i_kind) && $stable(i_last) && $stable(i_pixel_color))
        else $error("Stalled result changed before its transfer.");

endmodule

bind proportional_text_renderer_top prt_checker u_prt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_kind          (o_kind),
    .i_pixel_address (o_pixel_address),
    .i_pixel_color   (o_pixel_color),
    .i_last          (o_last)
);
